[rtl/young_tableau_min_queue_defines.svh]
// ----------------------------------------------------------------------------
// young_tableau_min_queue_defines
// Assertion macros for the young tableau queue RTL.
// ----------------------------------------------------------------------------
`ifndef YOUNG_TABLEAU_MIN_QUEUE_DEFINES_SVH
`define YOUNG_TABLEAU_MIN_QUEUE_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define YTQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define YTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ytq_pkg.sv]
// ----------------------------------------------------------------------------
// ytq_pkg
// Sizes, codes and types of the young tableau min queue.
// ----------------------------------------------------------------------------
package ytq_pkg;

	localparam int ROWS   = 8;
	localparam int COLS   = 8;
	localparam int DEPTH  = ROWS * COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int DATA_W = 32;

	localparam logic signed [DATA_W-1:0] MARK = 32'sh7FFF_FFFF;

	localparam logic ACT_INSERT  = 1'b0;
	localparam logic ACT_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK_RD,
		S_CHECK,
		S_STEP_RD,
		S_STEP_CMP,
		S_WB,
		S_FIN
	} state_t;

	typedef struct packed {
		logic                     ins;
		logic                     has_a;
		logic                     has_b;
		logic signed [DATA_W-1:0] va;
		logic signed [DATA_W-1:0] vb;
		logic signed [DATA_W-1:0] mov;
	} step_in_t;

	typedef struct packed {
		logic                     move;
		logic                     pick_b;
		logic signed [DATA_W-1:0] val;
	} step_res_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
	endfunction

endpackage

[rtl/ytq_ram.sv]
// ----------------------------------------------------------------------------
// ytq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ytq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[rtl/ytq_step.sv]
// ----------------------------------------------------------------------------
// ytq_step
// Sift step unit: pick a neighbor and decide whether the moving value swaps.
// ----------------------------------------------------------------------------
module ytq_step import ytq_pkg::*; (
	input  step_in_t  si,
	output step_res_t so
);

	logic a_lt_b;
	logic b_lt_a;
	logic signed [DATA_W-1:0] chosen;

	assign a_lt_b = si.va < si.vb;
	assign b_lt_a = si.vb < si.va;

	always_comb begin
		so.pick_b = si.has_b && (!si.has_a || (si.ins ? a_lt_b : b_lt_a));
		chosen    = so.pick_b ? si.vb : si.va;
		so.val    = chosen;
		so.move   = (si.has_a || si.has_b) &&
			(si.ins ? (chosen > si.mov) : (chosen < si.mov));
	end

endmodule

[rtl/young_tableau_min_queue.sv]
// Flow: one item at a time, taken only in idle; full, empty and invalid answers
// skip the sift, and a sift moves the item at most ROWS+COLS-2 cells.
// Each sift step is one neighbor read and one compare/write on the RAM.
// Reset: asynchronous, active low; clears 64 cell valid flags so the tableau
// reads as all empty at once, no clearing pass.
`include "young_tableau_min_queue_defines.svh"
// ----------------------------------------------------------------------------
// young_tableau_min_queue
// Min priority queue held as a sorted tableau with an iterative sift unit.
// ----------------------------------------------------------------------------
module young_tableau_min_queue import ytq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] item
	input  logic [0:0]        s_axis_tuser,   // [0] action
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] min_value
	output logic [1:0]        m_axis_tuser    // [1:0] status
);

	state_t state_q, state_d;

	logic [DEPTH-1:0]         valid_q;
	logic                     act_q;
	logic signed [DATA_W-1:0] item_q;
	logic signed [DATA_W-1:0] mov_q;
	logic signed [DATA_W-1:0] res_q;
	status_t                  stat_q;
	logic [ROW_W-1:0]         r_q;
	logic [COL_W-1:0]         c_q;
	logic                     vld_a_q;
	logic                     vld_b_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_data_q;
	status_t                  out_stat_q;

	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic [ADDR_W-1:0]        ram_raddr_a;
	logic [ADDR_W-1:0]        ram_raddr_b;
	logic [DATA_W-1:0]        ram_rdata_a;
	logic [DATA_W-1:0]        ram_rdata_b;
	logic                     accept;
	logic                     load_out;

	logic [ROW_W-1:0]         na_r;
	logic [COL_W-1:0]         nb_c;
	logic                     has_a;
	logic                     has_b;
	logic signed [DATA_W-1:0] va;
	logic signed [DATA_W-1:0] vb;
	status_t                  chk_stat;
	step_in_t                 step_in;
	step_res_t                step_res;

	ytq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(ram_raddr_a),
		.raddr_b(ram_raddr_b),
		.rdata_a(ram_rdata_a),
		.rdata_b(ram_rdata_b)
	);

	ytq_step u_step (
		.si(step_in),
		.so(step_res)
	);

	// neighbor a: up on insert, below on extract; neighbor b: left or right
	always_comb begin
		if (act_q == ACT_INSERT) begin
			has_a = r_q != '0;
			has_b = c_q != '0;
			na_r  = r_q - ROW_W'(1);
			nb_c  = c_q - COL_W'(1);
		end else begin
			has_a = r_q != ROW_W'(ROWS - 1);
			has_b = c_q != COL_W'(COLS - 1);
			na_r  = r_q + ROW_W'(1);
			nb_c  = c_q + COL_W'(1);
		end
	end

	assign va = vld_a_q ? $signed(ram_rdata_a) : MARK;
	assign vb = vld_b_q ? $signed(ram_rdata_b) : MARK;

	always_comb begin
		step_in.ins   = act_q == ACT_INSERT;
		step_in.has_a = has_a;
		step_in.has_b = has_b;
		step_in.va    = va;
		step_in.vb    = vb;
		step_in.mov   = mov_q;
	end

	always_comb begin
		if (act_q == ACT_INSERT) begin
			if (item_q == MARK) begin
				chk_stat = ST_INVALID;
			end else if (va != MARK) begin
				chk_stat = ST_FULL;
			end else begin
				chk_stat = ST_OK;
			end
		end else begin
			chk_stat = (va == MARK) ? ST_EMPTY : ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = S_CHECK_RD;
				end
			end
			S_CHECK_RD: state_d = S_CHECK;
			S_CHECK:    state_d = (chk_stat == ST_OK) ? S_STEP_RD : S_FIN;
			S_STEP_RD:  state_d = S_STEP_CMP;
			S_STEP_CMP: state_d = step_res.move ? S_STEP_RD : S_WB;
			S_WB:       state_d = S_FIN;
			S_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = cell_addr(r_q, c_q);
		ram_wdata     = mov_q;
		ram_raddr_a   = cell_addr(na_r, c_q);
		ram_raddr_b   = cell_addr(r_q, nb_c);
		load_out      = 1'b0;
		case (state_q)
			S_IDLE: s_axis_tready = 1'b1;
			S_CHECK_RD: begin
				ram_raddr_a = (act_q == ACT_INSERT) ? ADDR_W'(DEPTH - 1) : '0;
			end
			S_STEP_CMP: begin
				ram_we    = step_res.move;
				ram_wdata = step_res.val;
			end
			S_WB: ram_we = 1'b1;
			S_FIN: load_out = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_a_q <= valid_q[ram_raddr_a];
		vld_b_q <= valid_q[ram_raddr_b];
		if (accept) begin
			act_q  <= s_axis_tuser[0];
			item_q <= $signed(s_axis_tdata);
			mov_q  <= (s_axis_tuser[0] == ACT_INSERT) ? $signed(s_axis_tdata) : MARK;
			res_q  <= MARK;
		end
		if (state_q == S_CHECK) begin
			stat_q <= chk_stat;
			if (act_q == ACT_INSERT) begin
				r_q <= ROW_W'(ROWS - 1);
				c_q <= COL_W'(COLS - 1);
			end else begin
				r_q <= '0;
				c_q <= '0;
				if (chk_stat == ST_OK) begin
					res_q <= va;
				end
			end
		end
		if (state_q == S_STEP_CMP && step_res.move) begin
			if (step_res.pick_b) begin
				c_q <= nb_c;
			end else begin
				r_q <= na_r;
			end
		end
		if (load_out) begin
			out_data_q <= res_q;
			out_stat_q <= stat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_stat_q;

	`YTQ_ASSERT_NEXT(a_accept_busy, accept, state_q == S_CHECK_RD && !s_axis_tready, "busy after accept")
	`YTQ_ASSERT_NEXT(a_wb_fin, state_q == S_WB, state_q == S_FIN && valid_q[$past(ram_waddr)], "write-back lost")
	`YTQ_ASSERT_NEXT(a_mark_out, load_out && (stat_q != ST_OK || act_q == ACT_INSERT), m_axis_tvalid && m_axis_tdata == MARK, "non-extract result carries a value")
	`YTQ_ASSERT(a_no_wr_idle, !(ram_we && (state_q == S_IDLE || state_q == S_FIN)), "cell write outside sift")

endmodule

[test/tb_young_tableau_min_queue.sv]
// ----------------------------------------------------------------------------
// tb_young_tableau_min_queue
// Checks the tableau min queue against a cycle-free model of the 8x8 tableau.
// Directed items cover empty, invalid, extreme and tied values. Random
// fill (to reach full), drain and mixed phases follow, with gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_young_tableau_min_queue import ytq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam int RANDOM_ITEMS = 1450;

	typedef struct {
		logic                     action;
		logic signed [DATA_W-1:0] value;
	} request_t;

	typedef struct {
		logic signed [DATA_W-1:0] min_value;
		status_t                  status;
	} answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;   // [31:0] item
	logic [0:0]        s_axis_tuser = '0;   // [0] action
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;        // [31:0] min_value
	logic [1:0]        m_axis_tuser;        // [1:0] status

	request_t queued_requests[$];
	answer_t  pending_answers[$];
	logic signed [DATA_W-1:0] cells [ROWS][COLS];

	logic in_fire = 1'b0;
	int   gap_in = 0;
	int   calm_in = 0;
	int   stall_out = 0;
	int   calm_out = 0;
	int   fails = 0;
	int   occupancy = 0;
	int   random_count = 0;

	young_tableau_min_queue DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return $urandom;
		if (r < 75) return $signed($urandom_range(0, 16)) - 8;
		if (r < 85) begin
			case ($urandom_range(0, 4))
				0: return VAL_MIN;
				1: return VAL_MIN + 1;
				2: return MARK - 1;
				3: return -1;
				default: return 0;
			endcase
		end
		if (r < 97) return $urandom_range(0, 1000);
		return MARK;
	endfunction

	// Track a rough fill level so the random phases reach full and empty.
	task automatic add_request(input logic act, input logic signed [DATA_W-1:0] v);
		request_t q;
		q.action = act;
		q.value = v;
		queued_requests.push_back(q);
		if (act == ACT_INSERT && v != MARK && occupancy < DEPTH) occupancy++;
		if (act == ACT_EXTRACT && occupancy > 0) occupancy--;
	endtask

	task automatic add_phase(input int len, input int insert_pct);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < insert_pct) add_request(ACT_INSERT, pick_value());
			else add_request(ACT_EXTRACT, $urandom);
		end
		random_count += len;
	endtask

	function automatic answer_t tableau_apply(input logic act,
		input logic signed [DATA_W-1:0] v);
		answer_t a;
		int r, c, nr, nc;
		logic signed [DATA_W-1:0] t;
		a.min_value = MARK;
		a.status = ST_OK;
		if (act == ACT_INSERT) begin
			if (v == MARK) begin
				a.status = ST_INVALID;
			end else if (cells[ROWS-1][COLS-1] != MARK) begin
				a.status = ST_FULL;
			end else begin
				cells[ROWS-1][COLS-1] = v;
				r = ROWS - 1;
				c = COLS - 1;
				while (r > 0 || c > 0) begin
					if (r > 0 && c > 0) begin
						if (cells[r-1][c] >= cells[r][c-1]) begin
							nr = r - 1; nc = c;
						end else begin
							nr = r; nc = c - 1;
						end
					end else if (r > 0) begin
						nr = r - 1; nc = c;
					end else begin
						nr = r; nc = c - 1;
					end
					if (cells[nr][nc] <= v) break;
					t = cells[r][c];
					cells[r][c] = cells[nr][nc];
					cells[nr][nc] = t;
					r = nr;
					c = nc;
				end
			end
		end else begin
			if (cells[0][0] == MARK) begin
				a.status = ST_EMPTY;
			end else begin
				a.min_value = cells[0][0];
				cells[0][0] = MARK;
				r = 0;
				c = 0;
				while (r < ROWS - 1 || c < COLS - 1) begin
					if (r < ROWS - 1 && c < COLS - 1) begin
						if (cells[r][c+1] < cells[r+1][c]) begin
							nr = r; nc = c + 1;
						end else begin
							nr = r + 1; nc = c;
						end
					end else if (r < ROWS - 1) begin
						nr = r + 1; nc = c;
					end else begin
						nr = r; nc = c + 1;
					end
					if (cells[nr][nc] >= cells[r][c]) break;
					t = cells[r][c];
					cells[r][c] = cells[nr][nc];
					cells[nr][nc] = t;
					r = nr;
					c = nc;
				end
			end
		end
		return a;
	endfunction

	always @(negedge clk) begin
		request_t q;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (gap_in > 0) begin
				s_axis_tvalid <= 1'b0;
				gap_in <= gap_in - 1;
			end else if (queued_requests.size() > 0) begin
				q = queued_requests.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= q.value;
				s_axis_tuser <= q.action;
				if (calm_in > 0) begin
					calm_in <= calm_in - 1;
				end else if ($urandom_range(0, 49) == 0) begin
					calm_in <= $urandom_range(20, 60);
				end else begin
					gap_in <= gap_len();
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_out > 0) begin
			m_axis_tready <= 1'b0;
			stall_out <= stall_out - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (calm_out > 0) begin
				calm_out <= calm_out - 1;
			end else if ($urandom_range(0, 49) == 0) begin
				calm_out <= $urandom_range(20, 60);
			end else begin
				stall_out <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		answer_t a;
		in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_answers.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("%0t: result with none expected: min_value %0d status %0d",
						$realtime, $signed(m_axis_tdata), m_axis_tuser);
			end else begin
				a = pending_answers.pop_front();
				if (m_axis_tdata !== a.min_value) begin
					fails++;
					if (fails <= 10)
						$display("%0t: min_value expected %0d got %0d", $realtime,
							a.min_value, $signed(m_axis_tdata));
				end
				if (m_axis_tuser !== a.status) begin
					fails++;
					if (fails <= 10)
						$display("%0t: status expected %s got %0d", $realtime,
							a.status.name(), m_axis_tuser);
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			pending_answers.push_back(tableau_apply(s_axis_tuser[0], s_axis_tdata));
	end

	initial begin
		#(20_000_000);
		$display("tb_young_tableau_min_queue NOT OK");
		$finish;
	end

	initial begin
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++)
				cells[r][c] = MARK;

		add_request(ACT_EXTRACT, $urandom);
		add_request(ACT_INSERT, MARK);
		add_request(ACT_INSERT, VAL_MIN);
		add_request(ACT_INSERT, MARK - 1);
		add_request(ACT_INSERT, 0);
		add_request(ACT_INSERT, -1);
		add_request(ACT_INSERT, 7);
		add_request(ACT_INSERT, 7);
		add_request(ACT_INSERT, 7);
		add_request(ACT_INSERT, 32'sh5555_5555);
		add_request(ACT_INSERT, 32'shAAAA_AAAA);
		for (int i = 0; i < 10; i++) add_request(ACT_EXTRACT, $urandom);
		add_request(ACT_EXTRACT, 32'hFFFF_FFFF);
		add_request(ACT_INSERT, MARK);

		add_phase(72, 100);
		add_phase(72, 0);
		while (random_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: add_phase($urandom_range(60, 110), 90);
				1: add_phase($urandom_range(40, 90), 12);
				2: add_phase($urandom_range(20, 60), 50);
				default: add_phase($urandom_range(20, 60), occupancy > DEPTH / 2 ? 35 : 65);
			endcase
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (queued_requests.size() > 0 || s_axis_tvalid || pending_answers.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (fails == 0) begin
			$display("tb_young_tableau_min_queue OK");
		end else begin
			$display("tb_young_tableau_min_queue NOT OK");
		end
		$finish;
	end

endmodule
